@@ hdl/g2e_pkg.sv @@
// Shared types and constants for the geodetic to ECEF conversion pipeline.
// Used by the CORDIC and divider pipelines and by the top level.
`timescale 1ns / 1ps
package g2e_pkg;

    // Configuration register indexes.
    localparam logic CFG_SEMI_MAJOR = 1'b0;
    localparam logic CFG_ECC        = 1'b1;

    // Reset values of the configuration registers (WGS84).
    localparam logic [32:0] SEMI_MAJOR_RESET = 33'd6378137000;
    localparam logic [31:0] ECC_RESET        = 32'd28752143;

    // Latitude clamp in 1e-7 degrees; angle conversion and fold constants, Q30 radians.
    localparam logic [29:0]        LAT_LIMIT   = 30'd900000000;
    localparam logic [32:0]        DEG7_TO_RAD = 33'd8048910509;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_INV    = 34'sd652032875;

    // Arctangent table in Q30 for the CORDIC stages.
    localparam logic [29:0] ATAN_Q30 [31] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
    };

    // Divider geometry: dividend, quotient and divisor widths.
    localparam int DIV_NW = 65;
    localparam int DIV_QW = 50;
    localparam int DIV_DW = 32;

    // Sideband carried alongside the latitude CORDIC.
    typedef struct packed {
        logic              flip;
        logic              neg;
        logic signed [27:0] height;
    } lat_side_t;

    // Sideband carried alongside the longitude CORDIC.
    typedef struct packed {
        logic flip;
        logic neg;
    } lon_side_t;

    // Trigonometric terms and height carried through square root and divider.
    typedef struct packed {
        logic signed [27:0] height;
        logic [30:0]        slat_mag;
        logic               slat_neg;
        logic [30:0]        cc_mag;
        logic               cc_neg;
        logic [30:0]        cs_mag;
        logic               cs_neg;
    } trig_side_t;

endpackage

@@ hdl/g2e_cordic.sv @@
// Rotation-mode CORDIC pipeline, one micro-rotation per register stage.
// Depends on g2e_pkg for the gain and the arctangent table.
`timescale 1ns / 1ps
module g2e_cordic #(
    parameter int STAGES = 31,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [33:0]  z_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic signed [33:0]  x_out,
    output logic signed [33:0]  y_out,
    output logic [SIDE_W-1:0]   side_out
);

    logic signed [33:0] x_reg [STAGES];
    logic signed [33:0] y_reg [STAGES];
    logic signed [33:0] z_reg [STAGES-1];
    logic               valid_reg [STAGES];
    logic [SIDE_W-1:0]  side_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [33:0] x_src;
        logic signed [33:0] y_src;
        logic signed [33:0] z_src;
        logic               v_src;
        logic [SIDE_W-1:0]  s_src;
        logic signed [33:0] atan_val;
        logic signed [33:0] x_next;
        logic signed [33:0] y_next;

        // Stage sources: the first stage starts from the fixed gain vector.
        if (i == 0) begin : g_first
            assign x_src = g2e_pkg::GAIN_INV;
            assign y_src = '0;
            assign z_src = z_in;
            assign v_src = in_valid;
            assign s_src = side_in;
        end else begin : g_next
            assign x_src = x_reg[i-1];
            assign y_src = y_reg[i-1];
            assign z_src = z_reg[i-1];
            assign v_src = valid_reg[i-1];
            assign s_src = side_reg[i-1];
        end

        assign atan_val = $signed({4'b0000, g2e_pkg::ATAN_Q30[i]});

        // Rotate towards zero residual angle.
        always_comb
        begin
            if (!z_src[33])
            begin
                x_next = x_src - (y_src >>> i);
                y_next = y_src + (x_src >>> i);
            end
            else
            begin
                x_next = x_src + (y_src >>> i);
                y_next = y_src - (x_src >>> i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                side_reg[i] <= s_src;
            end
        end

        // The residual angle is not needed after the final stage.
        if (i < STAGES - 1) begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                    z_reg[i] <= z_src[33] ? z_src + atan_val : z_src - atan_val;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign x_out     = x_reg[STAGES-1];
    assign y_out     = y_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

@@ hdl/g2e_sqrt.sv @@
// Pipelined digit-by-digit square root of a 63-bit radicand, rounded to nearest.
// One result bit per stage plus a rounding stage; no package dependencies.
`timescale 1ns / 1ps
module g2e_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [62:0]        radicand,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               out_valid,
    output logic [31:0]        root,
    output logic [SIDE_W-1:0]  side_out
);

    localparam int STEPS = 32;

    logic [62:0]       v_reg [STEPS];
    logic [62:0]       r_reg [STEPS];
    logic              valid_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [31:0]       root_reg;
    logic              out_valid_reg;
    logic [SIDE_W-1:0] side_out_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
        logic [62:0]       v_src;
        logic [62:0]       r_src;
        logic              vld_src;
        logic [SIDE_W-1:0] s_src;
        logic [63:0]       trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_src   = radicand;
            assign r_src   = '0;
            assign vld_src = in_valid;
            assign s_src   = side_in;
        end else begin : g_next
            assign v_src   = v_reg[k-1];
            assign r_src   = r_reg[k-1];
            assign vld_src = valid_reg[k-1];
            assign s_src   = side_reg[k-1];
        end

        // Try to subtract the current root candidate.
        assign trial = {1'b0, r_src} + {1'b0, BIT};
        assign take  = {1'b0, v_src} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= take ? v_src - trial[62:0] : v_src;
                r_reg[k]    <= take ? (r_src >> 1) + BIT : r_src >> 1;
                side_reg[k] <= s_src;
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the root.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg     <= r_reg[STEPS-1][31:0]
                            + 32'(v_reg[STEPS-1] > r_reg[STEPS-1]);
            side_out_reg <= side_reg[STEPS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign side_out  = side_out_reg;

endmodule

@@ hdl/g2e_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on g2e_pkg for the dividend, divisor and quotient widths.
`timescale 1ns / 1ps
module g2e_div #(
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [g2e_pkg::DIV_NW-1:0]        dividend,
    input  logic [g2e_pkg::DIV_DW-1:0]        divisor,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic [g2e_pkg::DIV_QW-1:0]        quotient,
    output logic [SIDE_W-1:0]                 side_out
);

    localparam int NW = g2e_pkg::DIV_NW;
    localparam int QW = g2e_pkg::DIV_QW;
    localparam int DW = g2e_pkg::DIV_DW;
    localparam int CW = DW + QW;

    logic [NW-1:0]     rem_reg [QW-1];
    logic [DW-1:0]     den_reg [QW-1];
    logic [QW-1:0]     q_reg [QW];
    logic              valid_reg [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        localparam int B = QW - 1 - i;
        logic [NW-1:0]     rem_src;
        logic [DW-1:0]     den_src;
        logic [QW-1:0]     q_src;
        logic              vld_src;
        logic [SIDE_W-1:0] s_src;
        logic [CW-1:0]     shifted;
        logic              take;

        if (i == 0) begin : g_first
            assign rem_src = dividend;
            assign den_src = divisor;
            assign q_src   = '0;
            assign vld_src = in_valid;
            assign s_src   = side_in;
        end else begin : g_next
            assign rem_src = rem_reg[i-1];
            assign den_src = den_reg[i-1];
            assign q_src   = q_reg[i-1];
            assign vld_src = valid_reg[i-1];
            assign s_src   = side_reg[i-1];
        end

        // Compare the partial remainder with the divisor at this bit weight.
        assign shifted = CW'(den_src) << B;
        assign take    = CW'(rem_src) >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i]    <= {q_src[QW-2:0], take};
                side_reg[i] <= s_src;
            end
        end

        // Remainder and divisor are not needed after the last bit.
        if (i < QW - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= take ? rem_src - shifted[NW-1:0] : rem_src;
                    den_reg[i] <= den_src;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quotient  = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

@@ hdl/geodetic_to_ecef_top.sv @@
// Top level of the geodetic to ECEF converter: input conditioning, product
// stages, output saturation. Depends on g2e_pkg, g2e_cordic, g2e_sqrt, g2e_div.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------
//  item      item_valid/item_stall   latitude, longitude, height_mm
//  result    result_valid/result_stall ecef_x, ecef_y, ecef_z
//  cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item is taken every cycle unless a stalled result holds the pipeline; the
// path runs through the CORDIC stages, 33 square-root stages and 50 divider stages.
// Reset clears the valid bits and loads the WGS84 axis and eccentricity.
// A stalled result holds the whole pipeline; while the output register is empty
// or being taken, transfers continue every cycle.
`timescale 1ns / 1ps
module geodetic_to_ecef_top #(
    parameter int CORDIC_ITERATIONS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] height_mm,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [33:0] ecef_x,
    output logic signed [33:0] ecef_y,
    output logic signed [33:0] ecef_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [32:0]        cfg_data
);

    localparam int CORDIC_STAGES = (CORDIC_ITERATIONS < 31) ? CORDIC_ITERATIONS : 31;
    localparam int LAT_SW  = $bits(g2e_pkg::lat_side_t);
    localparam int LON_SW  = $bits(g2e_pkg::lon_side_t);
    localparam int TRIG_SW = $bits(g2e_pkg::trig_side_t);

    // Magnitude of a CORDIC output, clamped to one in Q30.
    function automatic logic [30:0] clamp_mag(input logic signed [33:0] v);
        logic [33:0] a;
        a = v[33] ? 34'(-v) : 34'(v);
        return (a > 34'd1073741824) ? 31'd1073741824 : a[30:0];
    endfunction

    // Apply a sign to a rounded magnitude and saturate to 34 bits.
    function automatic logic signed [33:0] sat_out(input logic [52:0] mag, input logic neg);
        logic signed [33:0] r;
        if (!neg)
            r = (mag > 53'd8589934591) ? 34'sd8589934591 : $signed(mag[33:0]);
        else
            r = (mag > 53'd8589934592) ? -34'sd8589934592 : $signed(34'(-mag[33:0]));
        return r;
    endfunction

    logic en;
    logic result_valid_reg;

    // Whole pipeline advances unless a waiting result is stalled.
    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;
    assign cfg_ready  = 1'b1;

    // Configuration registers.
    logic [32:0] semi_major_reg;
    logic [31:0] ecc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_major_reg <= g2e_pkg::SEMI_MAJOR_RESET;
            ecc_reg        <= g2e_pkg::ECC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                g2e_pkg::CFG_SEMI_MAJOR: semi_major_reg <= cfg_data;
                g2e_pkg::CFG_ECC:        ecc_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Stage 1: clamp latitude and split both angles into sign and magnitude.
    logic        v1_reg;
    logic [29:0] lat_mag1_reg;
    logic        lat_neg1_reg;
    logic [31:0] lon_mag1_reg;
    logic        lon_neg1_reg;
    logic signed [27:0] h1_reg;
    logic [30:0] lat_abs;
    logic [29:0] lat_mag1_next;
    logic [31:0] lon_mag1_next;

    always_comb
    begin
        lat_abs       = latitude[30] ? 31'(-latitude) : 31'(latitude);
        lat_mag1_next = (lat_abs > 31'(g2e_pkg::LAT_LIMIT)) ? g2e_pkg::LAT_LIMIT
                                                            : lat_abs[29:0];
        lon_mag1_next = longitude[31] ? 32'(-longitude) : 32'(longitude);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_mag1_reg <= lat_mag1_next;
            lat_neg1_reg <= latitude[30];
            lon_mag1_reg <= lon_mag1_next;
            lon_neg1_reg <= longitude[31];
            h1_reg       <= height_mm;
        end
    end

    // Stage 2: degrees to Q30 radians, rounded.
    logic        v2_reg;
    logic [31:0] z_lat2_reg;
    logic [31:0] z_lon2_reg;
    logic        lat_neg2_reg;
    logic        lon_neg2_reg;
    logic signed [27:0] h2_reg;
    logic [65:0] lat_prod;
    logic [65:0] lon_prod;

    always_comb
    begin
        lat_prod = 66'(lat_mag1_reg) * 66'(g2e_pkg::DEG7_TO_RAD) + (66'(1) << 31);
        lon_prod = 66'(lon_mag1_reg) * 66'(g2e_pkg::DEG7_TO_RAD) + (66'(1) << 31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_lat2_reg   <= lat_prod[63:32];
            z_lon2_reg   <= lon_prod[63:32];
            lat_neg2_reg <= lat_neg1_reg;
            lon_neg2_reg <= lon_neg1_reg;
            h2_reg       <= h1_reg;
        end
    end

    // Stage 3: fold angles beyond a right angle back into the first quadrant.
    logic               v3_reg;
    logic signed [33:0] z_lat3_reg;
    logic signed [33:0] z_lon3_reg;
    g2e_pkg::lat_side_t lat_side3_reg;
    g2e_pkg::lon_side_t lon_side3_reg;
    logic signed [33:0] z_lat_s;
    logic signed [33:0] z_lon_s;
    logic               flip_lat;
    logic               flip_lon;

    always_comb
    begin
        z_lat_s  = $signed({2'b00, z_lat2_reg});
        z_lon_s  = $signed({2'b00, z_lon2_reg});
        flip_lat = z_lat_s > g2e_pkg::HALF_PI_Q30;
        flip_lon = z_lon_s > g2e_pkg::HALF_PI_Q30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_lat3_reg           <= flip_lat ? g2e_pkg::PI_Q30 - z_lat_s : z_lat_s;
            z_lon3_reg           <= flip_lon ? g2e_pkg::PI_Q30 - z_lon_s : z_lon_s;
            lat_side3_reg.flip   <= flip_lat;
            lat_side3_reg.neg    <= lat_neg2_reg;
            lat_side3_reg.height <= h2_reg;
            lon_side3_reg.flip   <= flip_lon;
            lon_side3_reg.neg    <= lon_neg2_reg;
        end
    end

    // CORDIC pipelines for latitude and longitude.
    logic               c_lat_valid;
    logic               c_lon_valid;
    logic signed [33:0] x_lat;
    logic signed [33:0] y_lat;
    logic signed [33:0] x_lon;
    logic signed [33:0] y_lon;
    g2e_pkg::lat_side_t lat_side_c;
    g2e_pkg::lon_side_t lon_side_c;

    g2e_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (LAT_SW)
    ) u_cordic_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .z_in      (z_lat3_reg),
        .side_in   (lat_side3_reg),
        .out_valid (c_lat_valid),
        .x_out     (x_lat),
        .y_out     (y_lat),
        .side_out  (lat_side_c)
    );

    g2e_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (LON_SW)
    ) u_cordic_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .z_in      (z_lon3_reg),
        .side_in   (lon_side3_reg),
        .out_valid (c_lon_valid),
        .x_out     (x_lon),
        .y_out     (y_lon),
        .side_out  (lon_side_c)
    );

    // Stage 4: clamp sine and cosine and apply quadrant and angle signs.
    logic        v4_reg;
    logic [30:0] slat_mag4_reg;
    logic        slat_neg4_reg;
    logic [30:0] clat_mag4_reg;
    logic        clat_neg4_reg;
    logic [30:0] slon_mag4_reg;
    logic        slon_neg4_reg;
    logic [30:0] clon_mag4_reg;
    logic        clon_neg4_reg;
    logic signed [27:0] h4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= c_lat_valid && c_lon_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slat_mag4_reg <= clamp_mag(y_lat);
            slat_neg4_reg <= y_lat[33] ^ lat_side_c.neg;
            clat_mag4_reg <= clamp_mag(x_lat);
            clat_neg4_reg <= x_lat[33] ^ lat_side_c.flip;
            slon_mag4_reg <= clamp_mag(y_lon);
            slon_neg4_reg <= y_lon[33] ^ lon_side_c.neg;
            clon_mag4_reg <= clamp_mag(x_lon);
            clon_neg4_reg <= x_lon[33] ^ lon_side_c.flip;
            h4_reg        <= lat_side_c.height;
        end
    end

    // Stage 5: sin^2 of latitude and the two horizontal direction cosines.
    logic        v5_reg;
    logic [32:0] s2_5_reg;
    g2e_pkg::trig_side_t trig5_reg;
    logic [61:0] sq_sum;
    logic [61:0] cc_sum;
    logic [61:0] cs_sum;

    always_comb
    begin
        sq_sum = 62'(slat_mag4_reg) * 62'(slat_mag4_reg) + (62'(1) << 27);
        cc_sum = 62'(clat_mag4_reg) * 62'(clon_mag4_reg) + (62'(1) << 29);
        cs_sum = 62'(clat_mag4_reg) * 62'(slon_mag4_reg) + (62'(1) << 29);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_5_reg           <= sq_sum[60:28];
            trig5_reg.height   <= h4_reg;
            trig5_reg.slat_mag <= slat_mag4_reg;
            trig5_reg.slat_neg <= slat_neg4_reg;
            trig5_reg.cc_mag   <= cc_sum[60:30];
            trig5_reg.cc_neg   <= clat_neg4_reg ^ clon_neg4_reg;
            trig5_reg.cs_mag   <= cs_sum[60:30];
            trig5_reg.cs_neg   <= clat_neg4_reg ^ slon_neg4_reg;
        end
    end

    // Stage 6: t = e2 * sin^2, rounded to Q32.
    logic        v6_reg;
    logic [31:0] t6_reg;
    g2e_pkg::trig_side_t trig6_reg;
    logic [65:0] t_prod;

    assign t_prod = 66'(ecc_reg) * 66'(s2_5_reg) + (66'(1) << 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t6_reg    <= t_prod[63:32];
            trig6_reg <= trig5_reg;
        end
    end

    // Stage 7: w = 1 - t in Q32.
    logic        v7_reg;
    logic [32:0] w7_reg;
    g2e_pkg::trig_side_t trig7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w7_reg    <= (33'(1) << 32) - 33'(t6_reg);
            trig7_reg <= trig6_reg;
        end
    end

    // Square root of w scaled to Q62, giving the root in Q31.
    logic        sq_valid;
    logic [31:0] sq_root;
    g2e_pkg::trig_side_t trig_sq;

    g2e_sqrt #(
        .SIDE_W (TRIG_SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .radicand  ({w7_reg, 30'b0}),
        .side_in   (trig7_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (trig_sq)
    );

    // Stage 8: dividend a * 2^31 plus half the divisor for rounding.
    logic        v8_reg;
    logic [64:0] num8_reg;
    logic [31:0] den8_reg;
    g2e_pkg::trig_side_t trig8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num8_reg  <= {1'b0, semi_major_reg, 31'b0} + 65'(sq_root[31:1]);
            den8_reg  <= sq_root;
            trig8_reg <= trig_sq;
        end
    end

    // Prime-vertical radius N in millimetres.
    logic        dv_valid;
    logic [49:0] n_div;
    g2e_pkg::trig_side_t trig_dv;

    g2e_div #(
        .SIDE_W (TRIG_SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .dividend  (num8_reg),
        .divisor   (den8_reg),
        .side_in   (trig8_reg),
        .out_valid (dv_valid),
        .quotient  (n_div),
        .side_out  (trig_dv)
    );

    // Stage P1: partial products of N * (1 - e2).
    logic        p1_v_reg;
    logic [57:0] pp_lo1_reg;
    logic [57:0] pp_hi1_reg;
    logic [49:0] n1_reg;
    g2e_pkg::trig_side_t trig_p1_reg;
    logic [32:0] one_minus_e2;

    assign one_minus_e2 = (33'(1) << 32) - 33'(ecc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_v_reg <= 1'b0;
        else if (en)
            p1_v_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo1_reg  <= 58'(n_div[24:0]) * 58'(one_minus_e2);
            pp_hi1_reg  <= 58'(n_div[49:25]) * 58'(one_minus_e2);
            n1_reg      <= n_div;
            trig_p1_reg <= trig_dv;
        end
    end

    // Stage P2: combine and round N(1 - e2); horizontal radius N + h.
    logic        p2_v_reg;
    logic [49:0] np2_reg;
    logic signed [51:0] rad2_reg;
    g2e_pkg::trig_side_t trig_p2_reg;
    logic [82:0] np_sum;

    assign np_sum = (83'(pp_hi1_reg) << 25) + 83'(pp_lo1_reg) + (83'(1) << 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_v_reg <= 1'b0;
        else if (en)
            p2_v_reg <= p1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            np2_reg     <= np_sum[81:32];
            rad2_reg    <= $signed({2'b00, n1_reg})
                           + $signed({{24{trig_p1_reg.height[27]}}, trig_p1_reg.height});
            trig_p2_reg <= trig_p1_reg;
        end
    end

    // Stage P3: polar radius N(1 - e2) + h; both radii to sign and magnitude.
    logic        p3_v_reg;
    logic [50:0] rad_mag3_reg;
    logic        rad_neg3_reg;
    logic [50:0] radz_mag3_reg;
    logic        radz_neg3_reg;
    g2e_pkg::trig_side_t trig_p3_reg;
    logic signed [51:0] radz;

    assign radz = $signed({2'b00, np2_reg})
                  + $signed({{24{trig_p2_reg.height[27]}}, trig_p2_reg.height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_v_reg <= 1'b0;
        else if (en)
            p3_v_reg <= p2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_mag3_reg  <= rad2_reg[51] ? 51'(-rad2_reg) : 51'(rad2_reg);
            rad_neg3_reg  <= rad2_reg[51];
            radz_mag3_reg <= radz[51] ? 51'(-radz) : 51'(radz);
            radz_neg3_reg <= radz[51];
            trig_p3_reg   <= trig_p2_reg;
        end
    end

    // Stage P4: split products of radius and direction terms.
    logic        p4_v_reg;
    logic [56:0] x_lo4_reg;
    logic [55:0] x_hi4_reg;
    logic [56:0] y_lo4_reg;
    logic [55:0] y_hi4_reg;
    logic [56:0] z_lo4_reg;
    logic [55:0] z_hi4_reg;
    logic        x_neg4_reg;
    logic        y_neg4_reg;
    logic        z_neg4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_v_reg <= 1'b0;
        else if (en)
            p4_v_reg <= p3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_lo4_reg  <= 57'(rad_mag3_reg[25:0]) * 57'(trig_p3_reg.cc_mag);
            x_hi4_reg  <= 56'(rad_mag3_reg[50:26]) * 56'(trig_p3_reg.cc_mag);
            y_lo4_reg  <= 57'(rad_mag3_reg[25:0]) * 57'(trig_p3_reg.cs_mag);
            y_hi4_reg  <= 56'(rad_mag3_reg[50:26]) * 56'(trig_p3_reg.cs_mag);
            z_lo4_reg  <= 57'(radz_mag3_reg[25:0]) * 57'(trig_p3_reg.slat_mag);
            z_hi4_reg  <= 56'(radz_mag3_reg[50:26]) * 56'(trig_p3_reg.slat_mag);
            x_neg4_reg <= rad_neg3_reg ^ trig_p3_reg.cc_neg;
            y_neg4_reg <= rad_neg3_reg ^ trig_p3_reg.cs_neg;
            z_neg4_reg <= radz_neg3_reg ^ trig_p3_reg.slat_neg;
        end
    end

    // Stage P5: combine partial products and round the Q30 scaling.
    logic        p5_v_reg;
    logic [52:0] x_mag5_reg;
    logic [52:0] y_mag5_reg;
    logic [52:0] z_mag5_reg;
    logic        x_neg5_reg;
    logic        y_neg5_reg;
    logic        z_neg5_reg;
    logic [82:0] x_sum;
    logic [82:0] y_sum;
    logic [82:0] z_sum;

    always_comb
    begin
        x_sum = (83'(x_hi4_reg) << 26) + 83'(x_lo4_reg) + (83'(1) << 29);
        y_sum = (83'(y_hi4_reg) << 26) + 83'(y_lo4_reg) + (83'(1) << 29);
        z_sum = (83'(z_hi4_reg) << 26) + 83'(z_lo4_reg) + (83'(1) << 29);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_v_reg <= 1'b0;
        else if (en)
            p5_v_reg <= p4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_mag5_reg <= x_sum[82:30];
            y_mag5_reg <= y_sum[82:30];
            z_mag5_reg <= z_sum[82:30];
            x_neg5_reg <= x_neg4_reg;
            y_neg5_reg <= y_neg4_reg;
            z_neg5_reg <= z_neg4_reg;
        end
    end

    // Output register: sign, saturation, result transfer.
    logic signed [33:0] ecef_x_reg;
    logic signed [33:0] ecef_y_reg;
    logic signed [33:0] ecef_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= p5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ecef_x_reg <= sat_out(x_mag5_reg, x_neg5_reg);
            ecef_y_reg <= sat_out(y_mag5_reg, y_neg5_reg);
            ecef_z_reg <= sat_out(z_mag5_reg, z_neg5_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign ecef_x       = ecef_x_reg;
    assign ecef_y       = ecef_y_reg;
    assign ecef_z       = ecef_z_reg;

endmodule
